// ===== rtl/mrb_pkg.sv =====
// mrb_pkg: shared constants, types and fixed-point helpers of the modal resonator bank
// used by the channel interfaces and the top level
`default_nettype none
package mrb_pkg;

  localparam int WORD_BITS    = 32;
  localparam int MODE_DEPTH   = 1024;
  localparam int EXCITE_DEPTH = 512;

  localparam int MODE_AW = $clog2(MODE_DEPTH);
  localparam int EX_AW   = $clog2(EXCITE_DEPTH);
  localparam int CNT_W   = MODE_AW + 1;
  localparam int FRAC    = WORD_BITS - 2;
  localparam int PROD_W  = 2 * WORD_BITS;
  localparam int TERM_W  = WORD_BITS + 2;
  localparam int SUM_W   = TERM_W + 2;
  localparam int ACC_W   = TERM_W + CNT_W;

  // field widths of the channels
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 10;
  localparam int FIELD_W = 32;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;

  // configuration registers
  localparam int MC_W = 11;
  localparam int FL_W = 10;
  localparam int NL_W = 20;
  localparam logic [MC_W-1:0] MC_RESET = MC_W'(1);
  localparam logic [FL_W-1:0] FL_RESET = FL_W'(0);
  localparam logic [NL_W-1:0] NL_RESET = NL_W'(48000);

  // modes are only recomputed once the counter is past this value
  localparam logic [NL_W-1:0] WINDOW_START = NL_W'(2);

  localparam logic [CIDX_W-1:0] REG_MODE_COUNT     = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_FORCING_LENGTH = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_NOTE_LENGTH    = CIDX_W'(2);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK      = 2'd0,
    ACT_LOAD_MODE = 2'd1,
    ACT_LOAD_EXC  = 2'd2,
    ACT_STRIKE    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_SAT,
    S_MP,
    S_ACC,
    S_FIN
  } state_t;

  // product rounded from Q4.60 to Q4.30, half away from zero
  function automatic logic signed [TERM_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic [TERM_W-1:0] m;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    sum = mag + (PROD_W'(1) << (FRAC - 1));
    m   = sum[FRAC +: TERM_W];
    return p[PROD_W-1] ? $signed(-m) : $signed(m);
  endfunction

  // saturate to the signed word range
  function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    lo = {{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
    if (v > hi) return hi[WORD_BITS-1:0];
    if (v < lo) return lo[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mrb_in_if.sv =====
// mrb_in_if: input item channel of the resonator bank
// depends on mrb_pkg for field widths
`default_nettype none
interface mrb_in_if;
  import mrb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [IDX_W-1:0]          entry_index;
  logic signed [FIELD_W-1:0] coef_current;
  logic signed [FIELD_W-1:0] coef_previous;
  logic signed [FIELD_W-1:0] coef_force;
  logic signed [FIELD_W-1:0] coef_spatial;
  logic signed [FIELD_W-1:0] excitation_value;
  modport source (output valid, action, entry_index, coef_current, coef_previous,
                  coef_force, coef_spatial, excitation_value, input ready);
  modport sink (input valid, action, entry_index, coef_current, coef_previous,
                coef_force, coef_spatial, excitation_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/mrb_out_if.sv =====
// mrb_out_if: result channel of the resonator bank
// depends on mrb_pkg for field widths
`default_nettype none
interface mrb_out_if;
  import mrb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] sample;
  logic                      in_window;
  modport source (output valid, sample, in_window, input ready);
  modport sink (input valid, sample, in_window, output ready);
endinterface
`default_nettype wire

// ===== rtl/mrb_cfg_if.sv =====
// mrb_cfg_if: register write channel of the resonator bank
// depends on mrb_pkg for field widths
`default_nettype none
interface mrb_cfg_if;
  import mrb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] idx;
  logic [CDAT_W-1:0] wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/mrb_ram.sv =====
// mrb_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module mrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/modal_resonator_bank_synth_top.sv =====
// modal_resonator_bank_synth_top: bank of two-pole modal resonators, one sample per tick
// depends on mrb_pkg, mrb_in_if, mrb_out_if, mrb_cfg_if and mrb_ram
// a tick walks the active modes over the single shared 32x32 multiplier: inside the window a
// mode passes read, the multiply states, saturation, spatial product and accumulate, outside
// it the multiply states are skipped; the accepting cycle and the result cycle frame the tick;
// a result still waiting on out ready holds the block; a strike, and reset, sweep the mode
// state memories, with no input transfer meanwhile; register writes are taken at all times
`default_nettype none
module modal_resonator_bank_synth_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mrb_in_if.sink     in_ch,
  mrb_out_if.source  out_ch,
  mrb_cfg_if.sink    cfg_ch
);
  import mrb_pkg::*;

  // configuration registers
  logic [MC_W-1:0] mode_count_r;
  logic [FL_W-1:0] forcing_length_r;
  logic [NL_W-1:0] note_length_r;

  // sequencer state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] mi_r;        // mode index, also the sweep address
  logic [CNT_W-1:0] modes_r;     // active modes of this tick
  logic [NL_W-1:0]  tick_r;
  logic             window_r;
  logic             forced_r;

  // datapath
  logic signed [WORD_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]    p_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic signed [WORD_BITS-1:0] nv_r;
  logic signed [ACC_W-1:0]     acc_r;

  // result register
  logic                        out_valid_r;
  logic signed [WORD_BITS-1:0] out_sample_r;
  logic                        out_window_r;

  // ram ports
  logic [WORD_BITS-1:0] wn_rd, wb_rd, wf_rd, wp_rd, now_rd, bef_rd, ex_rd;
  logic                 st_we;
  logic [WORD_BITS-1:0] now_wd, bef_wd;
  logic                 wt_we, ex_we;

  logic in_xfer, cfg_xfer, out_xfer;
  logic [CNT_W-1:0] modes_in;
  logic [CNT_W-1:0] flen;
  logic             in_win, in_forced;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sample    = out_sample_r;
  assign out_ch.in_window = out_window_r;

  // counts clamp at the memory depths
  assign modes_in  = (mode_count_r > MC_W'(MODE_DEPTH)) ? CNT_W'(MODE_DEPTH)
                                                          : CNT_W'(mode_count_r);
  assign flen      = (forcing_length_r > FL_W'(EXCITE_DEPTH)) ? CNT_W'(EXCITE_DEPTH)
                                                                : CNT_W'(forcing_length_r);
  assign in_win    = (tick_r > WINDOW_START) && (tick_r < note_length_r);
  assign in_forced = tick_r < NL_W'(flen);

  // coefficient memories, written by a coefficient load, read along the mode walk
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MODE_DEPTH)) u_wn (
    .clk(clk), .we(wt_we), .waddr(in_ch.entry_index[MODE_AW-1:0]),
    .wdata(WORD_BITS'(in_ch.coef_current)), .raddr(mi_r[MODE_AW-1:0]), .rdata(wn_rd));
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MODE_DEPTH)) u_wb (
    .clk(clk), .we(wt_we), .waddr(in_ch.entry_index[MODE_AW-1:0]),
    .wdata(WORD_BITS'(in_ch.coef_previous)), .raddr(mi_r[MODE_AW-1:0]), .rdata(wb_rd));
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MODE_DEPTH)) u_wf (
    .clk(clk), .we(wt_we), .waddr(in_ch.entry_index[MODE_AW-1:0]),
    .wdata(WORD_BITS'(in_ch.coef_force)), .raddr(mi_r[MODE_AW-1:0]), .rdata(wf_rd));
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MODE_DEPTH)) u_wp (
    .clk(clk), .we(wt_we), .waddr(in_ch.entry_index[MODE_AW-1:0]),
    .wdata(WORD_BITS'(in_ch.coef_spatial)), .raddr(mi_r[MODE_AW-1:0]), .rdata(wp_rd));

  // excitation table, read at the tick counter for the whole walk
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(EXCITE_DEPTH)) u_ex (
    .clk(clk), .we(ex_we), .waddr(in_ch.entry_index[EX_AW-1:0]),
    .wdata(WORD_BITS'(in_ch.excitation_value)), .raddr(tick_r[EX_AW-1:0]), .rdata(ex_rd));

  // mode states; the history is shifted in place at each mode's accumulate step,
  // so a separate next-state memory is not kept
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MODE_DEPTH)) u_now (
    .clk(clk), .we(st_we), .waddr(mi_r[MODE_AW-1:0]),
    .wdata(now_wd), .raddr(mi_r[MODE_AW-1:0]), .rdata(now_rd));
  mrb_ram #(.WIDTH(WORD_BITS), .DEPTH(MODE_DEPTH)) u_bef (
    .clk(clk), .we(st_we), .waddr(mi_r[MODE_AW-1:0]),
    .wdata(bef_wd), .raddr(mi_r[MODE_AW-1:0]), .rdata(bef_rd));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (mi_r == CNT_W'(MODE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (action_t'(in_ch.action))
            ACT_STRIKE: state_nxt = S_CLEAR;
            ACT_TICK:   state_nxt = (modes_in == '0) ? S_FIN : S_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:  state_nxt = window_r ? S_M0 : S_SAT;
      S_M0:  state_nxt = S_M1;
      S_M1:  state_nxt = S_M2;
      S_M2:  state_nxt = S_M3;
      S_M3:  state_nxt = S_SAT;
      S_SAT: state_nxt = S_MP;
      S_MP:  state_nxt = S_ACC;
      S_ACC: state_nxt = (mi_r + CNT_W'(1) < modes_r) ? S_RD : S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, ram writes, multiplier operands
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    wt_we  = 1'b0;
    ex_we  = 1'b0;
    st_we  = 1'b0;
    now_wd = '0;
    bef_wd = '0;
    mul_a  = $signed(wn_rd);
    mul_b  = $signed(now_rd);
    case (state_r)
      S_CLEAR: st_we = 1'b1;
      S_IDLE: begin
        wt_we = in_xfer && (action_t'(in_ch.action) == ACT_LOAD_MODE)
                && (CNT_W'(in_ch.entry_index) < CNT_W'(MODE_DEPTH));
        ex_we = in_xfer && (action_t'(in_ch.action) == ACT_LOAD_EXC)
                && (CNT_W'(in_ch.entry_index) < CNT_W'(EXCITE_DEPTH));
      end
      S_M1: begin
        mul_a = $signed(wb_rd);
        mul_b = $signed(bef_rd);
      end
      S_M2: begin
        mul_a = $signed(wf_rd);
        mul_b = $signed(ex_rd);
      end
      S_MP: begin
        mul_a = $signed(wp_rd);
        mul_b = nv_r;
      end
      S_ACC: begin
        // history shift: before takes now, now takes the new value
        st_we  = 1'b1;
        now_wd = nv_r;
        bef_wd = now_rd;
      end
      default: ;
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_M1: sum_r <= SUM_W'(rnd_q(p_r));
      S_M2: sum_r <= sum_r + SUM_W'(rnd_q(p_r));
      S_M3: if (forced_r) sum_r <= sum_r + SUM_W'(rnd_q(p_r));
      S_SAT: nv_r <= window_r ? sat_w(ACC_W'(sum_r)) : $signed(now_rd);
      S_ACC: acc_r <= acc_r + ACC_W'(rnd_q(p_r));
      S_IDLE: acc_r <= '0;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      mi_r             <= '0;
      modes_r          <= '0;
      tick_r           <= '0;
      window_r         <= 1'b0;
      forced_r         <= 1'b0;
      out_valid_r      <= 1'b0;
      mode_count_r     <= MC_RESET;
      forcing_length_r <= FL_RESET;
      note_length_r    <= NL_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_xfer) begin
        case (cfg_ch.idx)
          REG_MODE_COUNT:     mode_count_r     <= cfg_ch.wdata[MC_W-1:0];
          REG_FORCING_LENGTH: forcing_length_r <= cfg_ch.wdata[FL_W-1:0];
          REG_NOTE_LENGTH:    note_length_r    <= cfg_ch.wdata[NL_W-1:0];
          default: ;
        endcase
      end

      // the result cycle reloads the register itself
      if (out_xfer && (state_r != S_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          mi_r <= (mi_r == CNT_W'(MODE_DEPTH - 1)) ? '0 : mi_r + CNT_W'(1);
        end
        S_IDLE: begin
          if (in_xfer) begin
            mi_r <= '0;
            if (action_t'(in_ch.action) == ACT_STRIKE) begin
              tick_r <= '0;
            end
            modes_r  <= modes_in;
            window_r <= in_win;
            forced_r <= in_forced;
          end
        end
        S_ACC: mi_r <= mi_r + CNT_W'(1);
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= sat_w(acc_r);
            out_window_r <= window_r;
            if (tick_r < note_length_r) tick_r <= tick_r + NL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
